// File: src/tgad_pkg.sv
// Shared types and constants of the TGA true-color stream decoder.
`timescale 1ns / 1ps

package tgad_pkg;

    // Header layout of an uncompressed TGA file.
    localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_DEPTH      = 5'd16;
    localparam logic [4:0] HDR_LAST       = 5'd17;

    localparam logic [7:0] CMAP_NONE       = 8'd0;
    localparam logic [7:0] TYPE_TRUECOLOR  = 8'd2;
    localparam logic [7:0] DEPTH_24        = 8'd24;
    localparam logic [7:0] DEPTH_32        = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

    // Command queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_ENABLE = 2'd0;
    localparam logic [1:0] CFG_KEY_RED    = 2'd1;
    localparam logic [1:0] CFG_KEY_GREEN  = 2'd2;
    localparam logic [1:0] CFG_KEY_BLUE   = 2'd3;

    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_BAD_TYPE  = 2'd2,
        KIND_BAD_DEPTH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_PIXELS = 3'b100
    } phase_t;

    typedef struct packed {
        logic       key_enable;
        logic [7:0] key_red;
        logic [7:0] key_green;
        logic [7:0] key_blue;
    } cfg_t;

    // One classified result on its way to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        keyable;   // 24-bit pixel, subject to the color key
        logic        depth32;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  bpp;
        logic        last;
    } cmd_t;

endpackage

// File: src/tgad_front.sv
// Byte parser: tracks the header and pixel layout and emits result commands.
`timescale 1ns / 1ps

module tgad_front import tgad_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic        type_ok_reg, type_ok_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [1:0]  idx_reg, idx_next;
    logic [23:0] gather_reg, gather_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] area_reg;
    logic        accept;
    logic        depth32;
    logic        pixel_done;

    assign in_ready   = ~q_full;
    assign accept     = in_valid & ~q_full;
    assign depth32    = (depth_reg == DEPTH_32);
    assign pixel_done = depth32 ? (idx_reg == 2'd3) : (idx_reg == 2'd2);

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        type_ok_next = type_ok_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        idx_next     = idx_reg;
        gather_next  = gather_reg;
        left_next    = left_reg;
        q_push       = 1'b0;
        q_cmd.kind    = KIND_HEADER;
        q_cmd.red     = '0;
        q_cmd.green   = '0;
        q_cmd.blue    = '0;
        q_cmd.alpha   = '0;
        q_cmd.keyable = 1'b0;
        q_cmd.depth32 = depth32;
        q_cmd.width   = width_reg;
        q_cmd.height  = height_reg;
        q_cmd.bpp     = depth_reg;
        q_cmd.last    = 1'b0;

        if (accept) begin
            if (in_start) begin
                // Byte zero of a new file; any file in progress is dropped.
                phase_next   = PH_HEADER;
                pos_next     = 5'd1;
                type_ok_next = 1'b1;
                width_next   = '0;
                height_next  = '0;
                depth_next   = '0;
                idx_next     = '0;
                gather_next  = '0;
                left_next    = '0;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        pos_next = pos_reg + 5'd1;
                        if (pos_reg == HDR_CMAP_TYPE && in_byte != CMAP_NONE) begin
                            type_ok_next = 1'b0;
                        end
                        if (pos_reg == HDR_IMAGE_TYPE && in_byte != TYPE_TRUECOLOR) begin
                            type_ok_next = 1'b0;
                        end
                        if (pos_reg == HDR_WIDTH_LO)  width_next[7:0]   = in_byte;
                        if (pos_reg == HDR_WIDTH_HI)  width_next[15:8]  = in_byte;
                        if (pos_reg == HDR_HEIGHT_LO) height_next[7:0]  = in_byte;
                        if (pos_reg == HDR_HEIGHT_HI) height_next[15:8] = in_byte;
                        if (pos_reg == HDR_DEPTH)     depth_next        = in_byte;
                        if (pos_reg == HDR_LAST) begin
                            q_push = 1'b1;
                            if (!type_ok_reg) begin
                                q_cmd.kind = KIND_BAD_TYPE;
                                q_cmd.last = 1'b1;
                                phase_next = PH_IDLE;
                            end else if (depth_reg != DEPTH_24 && !depth32) begin
                                q_cmd.kind = KIND_BAD_DEPTH;
                                q_cmd.last = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                // The area product was registered after byte 15.
                                left_next   = area_reg;
                                idx_next    = '0;
                                gather_next = '0;
                                q_cmd.kind  = KIND_HEADER;
                                if (area_reg == '0) begin
                                    q_cmd.last = 1'b1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_PIXELS;
                                end
                            end
                        end
                    end
                    PH_PIXELS: begin
                        if (!pixel_done) begin
                            case (idx_reg)
                                2'd0:    gather_next[7:0]   = in_byte;
                                2'd1:    gather_next[15:8]  = in_byte;
                                default: gather_next[23:16] = in_byte;
                            endcase
                            idx_next = idx_reg + 2'd1;
                        end else begin
                            q_push        = 1'b1;
                            q_cmd.kind    = KIND_PIXEL;
                            q_cmd.blue    = gather_reg[7:0];
                            q_cmd.green   = gather_reg[15:8];
                            q_cmd.red     = depth32 ? gather_reg[23:16] : in_byte;
                            q_cmd.alpha   = depth32 ? in_byte : ALPHA_OPAQUE;
                            q_cmd.keyable = ~depth32;
                            q_cmd.last    = (left_reg == 32'd1);
                            idx_next      = '0;
                            gather_next   = '0;
                            left_next     = left_reg - 32'd1;
                            if (left_reg == 32'd1) begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        // Stray bytes outside a file are dropped.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_ok_reg <= type_ok_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        depth_reg   <= depth_next;
        gather_reg  <= gather_next;
        left_reg    <= left_next;
        area_reg    <= width_reg * height_reg;
    end

endmodule

// File: src/tgad_queue.sv
// Short command queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module tgad_queue import tgad_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/tgad_back.sv
// Output stage: applies the color key and holds the result for the sink.
`timescale 1ns / 1ps

module tgad_back import tgad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        head_cmd,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output kind_t       out_kind,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        out_has_alpha,
    output logic [15:0] out_width,
    output logic [15:0] out_height,
    output logic [7:0]  out_bpp,
    output logic        out_last
);

    logic        valid_reg;
    kind_t       kind_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, bpp_reg;
    logic        has_alpha_reg, last_reg;
    logic [15:0] width_reg, height_reg;
    logic        key_hit;

    assign q_pop   = ~q_empty & (~valid_reg | out_ready);
    assign key_hit = head_cmd.keyable & cfg.key_enable
                   & (head_cmd.red == cfg.key_red)
                   & (head_cmd.green == cfg.key_green)
                   & (head_cmd.blue == cfg.key_blue);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg      <= head_cmd.kind;
            red_reg       <= head_cmd.red;
            green_reg     <= head_cmd.green;
            blue_reg      <= head_cmd.blue;
            alpha_reg     <= key_hit ? 8'd0 : head_cmd.alpha;
            has_alpha_reg <= head_cmd.depth32 | cfg.key_enable;
            width_reg     <= head_cmd.width;
            height_reg    <= head_cmd.height;
            bpp_reg       <= head_cmd.bpp;
            last_reg      <= head_cmd.last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = kind_reg;
    assign out_red       = red_reg;
    assign out_green     = green_reg;
    assign out_blue      = blue_reg;
    assign out_alpha     = alpha_reg;
    assign out_has_alpha = has_alpha_reg;
    assign out_width     = width_reg;
    assign out_height    = height_reg;
    assign out_bpp       = bpp_reg;
    assign out_last      = last_reg;

endmodule

// File: src/tga_truecolor_stream_decoder.sv
// Top level of the streaming decoder for uncompressed true-color TGA files.
`timescale 1ns / 1ps
// A byte that completes a header or a pixel pushes its command into the queue at the edge
//   that accepts it; the output register takes the command when it holds no item or the
//   sink takes its item, and then raises m_tvalid.
// Throughput: one byte per cycle; s_tready drops only when the four-entry command queue
//   is full because the sink stalls.
// Reset: aresetn is synchronous and active low; it idles the parser, empties the queue,
//   drops the output valid and returns all key registers to zero.

module tga_truecolor_stream_decoder import tgad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Byte stream in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] file_start
    // Result stream out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
                                    // [32] has_alpha, [48:33] width, [64:49] height,
                                    // [72:65] bits_per_pixel, [79:73] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    cfg_t        cfg_reg;
    logic        q_push, q_pop, q_empty, q_full;
    cmd_t        push_cmd, head_cmd;
    kind_t       out_kind;
    logic [7:0]  out_red, out_green, out_blue, out_alpha, out_bpp;
    logic        out_has_alpha;
    logic [15:0] out_width, out_height;

    // The user must write the key registers only between files (the block does not enforce
    // it), so the output stage can read them at the moment each result is formed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KEY_ENABLE: cfg_reg.key_enable <= cfg_wdata[0];
                CFG_KEY_RED:    cfg_reg.key_red    <= cfg_wdata;
                CFG_KEY_GREEN:  cfg_reg.key_green  <= cfg_wdata;
                CFG_KEY_BLUE:   cfg_reg.key_blue   <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // The parser follows the header and the pixel byte order and pushes one
    // command for each byte that finishes a header or a pixel.
    tgad_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_start (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // The queue lets the parser keep taking bytes while the sink holds a result.
    tgad_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The output stage resolves the color key and alpha flag, then registers the item.
    tgad_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_cmd      (head_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (out_kind),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_alpha     (out_alpha),
        .out_has_alpha (out_has_alpha),
        .out_width     (out_width),
        .out_height    (out_height),
        .out_bpp       (out_bpp),
        .out_last      (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {7'd0, out_bpp, out_height, out_width, out_has_alpha,
                      out_alpha, out_blue, out_green, out_red};

endmodule

// File: verif/tga_result_checker.sv
// Checker of the TGA true-color stream decoder: predicts each result and compares it.
`timescale 1ns / 1ps

module tga_result_checker import tgad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] file_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
                                    // [32] has_alpha, [48:33] width, [64:49] height,
                                    // [72:65] bits_per_pixel, [79:73] zero
    input  logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    typedef enum logic [2:0] {
        DEC_IDLE   = 3'b001,
        DEC_HEADER = 3'b010,
        DEC_PIXELS = 3'b100
    } dec_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_alpha;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  bpp;
        logic        last;
    } tga_result_t;

    tga_result_t awaited_results[$];

    logic        key_on;
    logic [7:0]  key_r, key_g, key_b;

    dec_phase_t  dec_phase;
    logic [4:0]  hdr_pos;
    logic        type_good;
    logic [15:0] img_w, img_h;
    logic [7:0]  img_bpp;
    logic [1:0]  byte_idx;
    logic [23:0] gather;
    logic [31:0] pix_left;

    // Header fields travel with every result of the file, error results included.
    function automatic tga_result_t make_result(input kind_t k, input logic [7:0] r,
                                                input logic [7:0] g, input logic [7:0] b,
                                                input logic [7:0] a, input logic lst);
        tga_result_t res;
        res.kind      = k;
        res.red       = r;
        res.green     = g;
        res.blue      = b;
        res.alpha     = a;
        res.has_alpha = (img_bpp == DEPTH_32) || key_on;
        res.width     = img_w;
        res.height    = img_h;
        res.bpp       = img_bpp;
        res.last      = lst;
        return res;
    endfunction

    task automatic take_header_byte(input logic [4:0] pos, input logic [7:0] b);
        if (pos == HDR_CMAP_TYPE && b != CMAP_NONE) type_good = 1'b0;
        if (pos == HDR_IMAGE_TYPE && b != TYPE_TRUECOLOR) type_good = 1'b0;
        case (pos)
            HDR_WIDTH_LO:  img_w[7:0]  = b;
            HDR_WIDTH_HI:  img_w[15:8] = b;
            HDR_HEIGHT_LO: img_h[7:0]  = b;
            HDR_HEIGHT_HI: img_h[15:8] = b;
            HDR_DEPTH:     img_bpp     = b;
            default: ;
        endcase
        hdr_pos = pos + 5'd1;
        if (pos == HDR_LAST) begin
            // A bad type is reported ahead of a bad depth.
            if (!type_good) begin
                dec_phase = DEC_IDLE;
                awaited_results.push_back(make_result(KIND_BAD_TYPE, 8'd0, 8'd0, 8'd0, 8'd0,
                                                      1'b1));
            end else if (img_bpp != DEPTH_24 && img_bpp != DEPTH_32) begin
                dec_phase = DEC_IDLE;
                awaited_results.push_back(make_result(KIND_BAD_DEPTH, 8'd0, 8'd0, 8'd0, 8'd0,
                                                      1'b1));
            end else begin
                pix_left = 32'(img_w) * 32'(img_h);
                byte_idx = 2'd0;
                gather   = 24'd0;
                if (pix_left == 0) begin
                    dec_phase = DEC_IDLE;
                    awaited_results.push_back(make_result(KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0,
                                                          1'b1));
                end else begin
                    dec_phase = DEC_PIXELS;
                    awaited_results.push_back(make_result(KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0,
                                                          1'b0));
                end
            end
        end
    endtask

    task automatic take_pixel_byte(input logic [7:0] b);
        logic [7:0] r, g, bl, a;
        logic       done;
        if (byte_idx != 2'd3) gather[8*byte_idx +: 8] = b;
        if ((img_bpp == DEPTH_24 && byte_idx < 2'd2) || (img_bpp == DEPTH_32 && byte_idx < 2'd3))
        begin
            byte_idx = byte_idx + 2'd1;
        end else begin
            // Stored order is blue, green, red, then alpha for 32-bit pixels.
            bl = gather[7:0];
            g  = gather[15:8];
            r  = gather[23:16];
            if (img_bpp == DEPTH_32) a = b;
            else if (key_on && r == key_r && g == key_g && bl == key_b) a = 8'd0;
            else a = ALPHA_OPAQUE;
            byte_idx = 2'd0;
            gather   = 24'd0;
            pix_left = pix_left - 32'd1;
            done     = (pix_left == 0);
            if (done) dec_phase = DEC_IDLE;
            awaited_results.push_back(make_result(KIND_PIXEL, r, g, bl, a, done));
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first);
        if (first) begin
            // A start flag always opens a new header, dropping any file in progress.
            dec_phase = DEC_HEADER;
            type_good = 1'b1;
            img_w     = 16'd0;
            img_h     = 16'd0;
            img_bpp   = 8'd0;
            byte_idx  = 2'd0;
            gather    = 24'd0;
            pix_left  = 32'd0;
            take_header_byte(5'd0, b);
        end else if (dec_phase == DEC_HEADER) begin
            if (hdr_pos > HDR_LAST) dec_phase = DEC_IDLE;
            else take_header_byte(hdr_pos, b);
        end else if (dec_phase == DEC_PIXELS) begin
            take_pixel_byte(b);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result();
        tga_result_t want;
        if (awaited_results.size() == 0) begin
            $error("result of kind %0d arrived with no result expected", m_tuser);
            mismatches++;
        end else begin
            want = awaited_results.pop_front();
            check_field("kind", want.kind, m_tuser);
            check_field("red", want.red, m_tdata[7:0]);
            check_field("green", want.green, m_tdata[15:8]);
            check_field("blue", want.blue, m_tdata[23:16]);
            check_field("alpha", want.alpha, m_tdata[31:24]);
            check_field("has_alpha", want.has_alpha, m_tdata[32]);
            check_field("width", want.width, m_tdata[48:33]);
            check_field("height", want.height, m_tdata[64:49]);
            check_field("bits_per_pixel", want.bpp, m_tdata[72:65]);
            check_field("last", want.last, m_tlast);
        end
    endtask

    // Outputs are checked before the byte of the same edge is predicted; the byte's
    // own result still has to pass through the queue and the output register.
    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_results.delete();
            mismatches = 0;
            key_on    = 1'b0;
            key_r     = 8'd0;
            key_g     = 8'd0;
            key_b     = 8'd0;
            dec_phase = DEC_IDLE;
            hdr_pos   = 5'd0;
            type_good = 1'b0;
            img_w     = 16'd0;
            img_h     = 16'd0;
            img_bpp   = 8'd0;
            byte_idx  = 2'd0;
            gather    = 24'd0;
            pix_left  = 32'd0;
        end else begin
            if (m_tvalid && m_tready) compare_result();
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_ENABLE: key_on = cfg_wdata[0];
                    CFG_KEY_RED:    key_r  = cfg_wdata;
                    CFG_KEY_GREEN:  key_g  = cfg_wdata;
                    CFG_KEY_BLUE:   key_b  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
        end
        outstanding = awaited_results.size();
    end

endmodule

// File: verif/tga_truecolor_stream_decoder_tb.sv
// Top of the testbench for the TGA true-color stream decoder: stimulus and verdict.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_tb import tgad_pkg::*; ();

    // The limit leaves a wide margin over the longest expected run.
    localparam int CYCLE_LIMIT  = 200000;
    // One long sink hold-off, well beyond what the four-entry command queue can absorb.
    localparam int HOLD_CYCLES  = 400;
    // Random file bytes per key setting; with the directed files and the closing files,
    // five settings bring the run to roughly 600 bytes.
    localparam int PHASE_BYTES  = 28;
    localparam int PHASES       = 5;
    // Extra wait after the last awaited result has left, before the next key write.
    localparam int DRAIN_CYCLES = 4;
    localparam int GAP_PERCENT  = 11;
    localparam int HEADER_BYTES = int'(HDR_LAST) + 1;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;     // [7:0] data_byte
    logic        s_tuser   = 1'b0;     // [0] file_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;              // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
                                       // [32] has_alpha, [48:33] width, [64:49] height,
                                       // [72:65] bits_per_pixel, [79:73] zero
    logic [1:0]  m_tuser;              // [1:0] kind
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_ENABLE;
    logic [7:0]  cfg_wdata = 8'd0;

    int          mismatches;
    int          outstanding;

    // Stimulus-side copy of the key, so that pixels can be aimed at it.
    logic        key_on = 1'b0;
    logic [7:0]  key_r  = 8'd0;
    logic [7:0]  key_g  = 8'd0;
    logic [7:0]  key_b  = 8'd0;

    // Idling controls. The source flag is only used by the stimulus process; the sink
    // flags are written with nonblocking assignments and read by the sink process.
    logic        src_gaps   = 1'b1;
    logic        sink_gaps  = 1'b1;
    logic        stall_req  = 1'b0;
    logic        stall_done = 1'b0;
    int          hold_left  = 0;

    int unsigned file_bytes = 0;
    int unsigned cycle_count = 0;

    tga_truecolor_stream_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tga_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The run ends here if the decoder stops moving items.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("** tga_truecolor_stream_decoder: FAILED **");
            $finish;
        end
    end

    // Sink side. Random stalls while sink_gaps is set; once stall_req rises, the sink
    // refuses results without a break until hold_left counts down, so that the command queue
    // fills and the decoder has to drop s_tready while the source keeps offering bytes.
    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !(sink_gaps && $urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // Offers one byte and returns at the edge where it is taken. The valid line is left
    // high, so the next byte or gap changes it in the following step only once.
    task automatic send_byte(input logic [7:0] b, input logic first);
        while (src_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every predicted result has left the decoder, plus the pipeline depth,
    // so that a key write cannot overtake a result still inside.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all four key registers back to back; the enable is lowered once at the end.
    task automatic load_key(input logic en, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
        key_on = en;
        key_r  = r;
        key_g  = g;
        key_b  = b;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY_ENABLE;
        cfg_wdata <= {7'd0, en};
        @(posedge aclk);
        cfg_index <= CFG_KEY_RED;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_index <= CFG_KEY_GREEN;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_index <= CFG_KEY_BLUE;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sends an 18-byte header, or only its first cut bytes when cut is nonzero. The
    // ID length, color-map spec, origin and descriptor bytes are random filler.
    task automatic send_header(input logic [7:0] cmap, input logic [7:0] itype,
                               input logic [7:0] depth, input logic [15:0] w,
                               input logic [15:0] h, input int unsigned cut);
        logic [7:0]  hdr [HEADER_BYTES];
        int unsigned n;
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        hdr[HDR_CMAP_TYPE]  = cmap;
        hdr[HDR_IMAGE_TYPE] = itype;
        hdr[HDR_WIDTH_LO]   = w[7:0];
        hdr[HDR_WIDTH_HI]   = w[15:8];
        hdr[HDR_HEIGHT_LO]  = h[7:0];
        hdr[HDR_HEIGHT_HI]  = h[15:8];
        hdr[HDR_DEPTH]      = depth;
        n = (cut == 0 || cut > HEADER_BYTES) ? HEADER_BYTES : cut;
        for (int i = 0; i < n; i++) begin
            send_byte(hdr[i], i == 0);
            file_bytes++;
        end
    endtask

    // Sends npix pixels in stored order (blue, green, red, alpha), stopping after cut
    // bytes when cut is nonzero. A good share of 24-bit pixels hit the key exactly, and
    // some miss it by one channel, whether the key is enabled or not.
    task automatic send_pixels(input logic [7:0] depth, input int unsigned npix,
                               input int unsigned cut);
        logic [7:0]  bgra [4];
        int unsigned nb;
        int unsigned sent;
        int unsigned roll;
        nb   = (depth == DEPTH_32) ? 4 : 3;
        sent = 0;
        for (int p = 0; p < npix; p++) begin
            roll = $urandom_range(0, 99);
            foreach (bgra[i]) bgra[i] = 8'($urandom);
            if (depth == DEPTH_24 && roll < 35) begin
                bgra[0] = key_b;
                bgra[1] = key_g;
                bgra[2] = key_r;
                if (roll >= 25) bgra[$urandom_range(0, 2)] = 8'($urandom);
            end else if (depth == DEPTH_32 && roll < 15) begin
                bgra[3] = 8'd0;
            end else if (depth == DEPTH_32 && roll < 30) begin
                bgra[3] = 8'hFF;
            end
            for (int k = 0; k < nb; k++) begin
                if (cut != 0 && sent == cut) return;
                send_byte(bgra[k], 1'b0);
                sent++;
                file_bytes++;
            end
        end
    endtask

    // A small, complete 24-bit file that leaves the decoder idle.
    task automatic close_file();
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_24, 16'd1, 16'd1, 0);
        send_pixels(DEPTH_24, 1, 0);
    endtask

    // One random file. Most are well-formed small images so that pixel decoding gets
    // most of the traffic; the rest are empty images, bad types, bad depths, files cut
    // short (the next start flag restarts the decoder) and stray bytes.
    task automatic send_random_file();
        int unsigned roll;
        int unsigned npix;
        int unsigned cut;
        logic [7:0]  cmap, itype, depth;
        logic [15:0] w, h;
        roll  = $urandom_range(0, 99);
        cmap  = CMAP_NONE;
        itype = TYPE_TRUECOLOR;
        depth = ($urandom_range(0, 2) == 0) ? DEPTH_32 : DEPTH_24;
        w     = 16'($urandom_range(1, 3));
        h     = 16'($urandom_range(1, 3));
        cut   = 0;
        if ($urandom_range(0, 9) == 0) begin
            w = 16'($urandom_range(4, 16));
            h = 16'd1;
        end
        if (roll < 75) begin
            // Well-formed image with random pixel content.
        end else if (roll < 80) begin
            // Zero pixels: only the header result, flagged last. The other dimension
            // takes any value, the largest included.
            if ($urandom_range(0, 1) == 1) begin
                w = 16'd0;
                h = 16'($urandom);
            end else begin
                w = 16'($urandom);
                h = 16'd0;
            end
        end else if (roll < 87) begin
            // Unsupported type; the depth may be bad too and must not win.
            cmap  = ($urandom_range(0, 1) == 1) ? 8'($urandom) : CMAP_NONE;
            itype = 8'($urandom);
            if (cmap == CMAP_NONE && itype == TYPE_TRUECOLOR) itype = ~itype;
            if ($urandom_range(0, 1) == 1) depth = 8'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end else if (roll < 92) begin
            depth = 8'($urandom);
            if (depth == DEPTH_24 || depth == DEPTH_32) depth = depth ^ 8'h01;
            w = 16'($urandom);
            h = 16'($urandom);
        end else if (roll < 98) begin
            npix = 32'(w) * 32'(h);
            cut  = $urandom_range(1, HEADER_BYTES + npix * ((depth == DEPTH_32) ? 4 : 3) - 1);
        end else begin
            // Stray bytes without a start flag; ignored unless a cut file is still open.
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            return;
        end
        npix = 32'(w) * 32'(h);
        send_header(cmap, itype, depth, w, h, cut);
        if (cut != 0 && cut <= HEADER_BYTES) return;
        if (cmap == CMAP_NONE && itype == TYPE_TRUECOLOR &&
            (depth == DEPTH_24 || depth == DEPTH_32)) begin
            send_pixels(depth, npix, (cut == 0) ? 0 : cut - HEADER_BYTES);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every key register gets written right after reset; black is the key.
        load_key(1'b1, 8'h00, 8'h00, 8'h00);

        // Two 24-bit pixels: the first equals the key and turns transparent, the
        // second is white and stays opaque.
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_24, 16'd2, 16'd1, 0);
        for (int k = 0; k < 6; k++) send_byte((k < 3) ? 8'h00 : 8'hFF, 1'b0);

        // 32-bit pixels carry their own alpha, here both extremes; the key plays no part.
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_32, 16'd1, 16'd2, 0);
        for (int k = 0; k < 8; k++) send_byte((k < 4) ? 8'h00 : 8'hFF, 1'b0);

        // A color map is not supported, and a bad type is reported ahead of a bad depth.
        send_header(8'h01, TYPE_TRUECOLOR, DEPTH_24, 16'hFFFF, 16'hFFFF, 0);
        send_header(CMAP_NONE, 8'd10, 8'd16, 16'hFFFF, 16'h0000, 0);

        // Unsupported depths at both ends of the byte.
        send_header(CMAP_NONE, TYPE_TRUECOLOR, 8'h00, 16'h0001, 16'hFFFF, 0);
        send_header(CMAP_NONE, TYPE_TRUECOLOR, 8'hFF, 16'h8000, 16'h0080, 0);

        // Empty images end with the header result, flagged last.
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_24, 16'hFFFF, 16'h0000, 0);
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_32, 16'h0000, 16'hFFFF, 0);

        // Bytes outside any file are dropped.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);

        // A start flag in the middle of a header, then in the middle of pixel data,
        // drops the open file without a result.
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_24, 16'd2, 16'd2, 9);
        send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_32, 16'd2, 16'd1, 0);
        send_pixels(DEPTH_32, 2, 6);
        close_file();

        // Random files under a series of key settings. Each setting is loaded only
        // after the decoder has gone quiet.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_key(1'b1, 8'hFF, 8'hFF, 8'hFF);
                1: begin
                    // A long stretch with neither side idling.
                    src_gaps   = 1'b0;
                    sink_gaps <= 1'b0;
                    load_key(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                2: begin
                    src_gaps   = 1'b1;
                    sink_gaps <= 1'b1;
                    load_key(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
                    // The sink holds off now while a 16-pixel 32-bit image streams in.
                    stall_req <= 1'b1;
                    send_header(CMAP_NONE, TYPE_TRUECOLOR, DEPTH_32, 16'd4, 16'd4, 0);
                    send_pixels(DEPTH_32, 16, 0);
                end
                default: load_key(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                                  8'($urandom));
            endcase
            file_bytes = 0;
            while (file_bytes < PHASE_BYTES) send_random_file();
            close_file();
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("** tga_truecolor_stream_decoder: PASSED **");
        else
            $display("** tga_truecolor_stream_decoder: FAILED **");
        $finish;
    end

endmodule
